### src/relr_pkg.sv
// Shared types and constants of the RELR relocation decoder.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package relr_pkg;

   // Field widths
   localparam int AddrWidth  = 64;
   localparam int EntryWidth = 64;
   localparam int BitmapBits = 63;
   localparam int WordBytes  = 8;

   // Cursor steps: one word after an address entry, one bitmap span after a bitmap entry
   localparam logic [AddrWidth-1:0] WordStep = AddrWidth'(WordBytes);
   localparam logic [AddrWidth-1:0] RunStep  = AddrWidth'(BitmapBits * WordBytes);

   // Register port: one 64-bit register, 8-byte spacing
   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 64;
   localparam int CsrIndexBit  = 3;
   localparam logic RegLoadBase = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ADV_WORD,
      ST_ADV_RUN
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic scan_step;
      logic advance_word;
      logic advance_run;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic slot_free;
      logic entry_even;
      logic cursor_valid;
      logic map_bit;
      logic map_last;
   } status_type;

endpackage

`default_nettype wire

### src/relr_if.sv
// Valid/ready channel interfaces for the entry stream and the patch address stream.
// Depends on relr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface relr_req_if import relr_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [EntryWidth-1:0] entry;
   logic                  table_end;

   modport source (output valid, output entry, output table_end, input ready);
   modport sink   (input valid, input entry, input table_end, output ready);
endinterface

interface relr_rsp_if import relr_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [AddrWidth-1:0] patch_address;
   logic                 last_of_run;

   modport source (output valid, output patch_address, output last_of_run, input ready);
   modport sink   (input valid, input patch_address, input last_of_run, output ready);
endinterface

`default_nettype wire

### src/relr_datapath.sv
// Datapath of the RELR decoder: cursor, bitmap shift register, scan address, output register.
// Depends on relr_pkg; driven by relr_ctrl through cmd_type commands.
`timescale 1ns / 1ps
`default_nettype none

module relr_datapath import relr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [AddrWidth-1:0]  load_base,
   input  wire logic [EntryWidth-1:0] req_entry,
   input  wire logic                  req_table_end,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [AddrWidth-1:0]       rsp_patch_address,
   output logic                       rsp_last_of_run
);

   logic [AddrWidth-1:0]  cursor_ff, cursor_in;
   logic                  cursor_valid_ff, cursor_valid_in;
   logic [BitmapBits-1:0] map_ff, map_in;
   logic [AddrWidth-1:0]  scan_addr_ff, scan_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [AddrWidth-1:0]  rsp_addr_ff, rsp_addr_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  entry_even;
   logic                  map_last;
   logic                  slot_free;
   logic                  load_out;
   logic [AddrWidth-1:0]  entry_sum;

   assign entry_even = ~req_entry[0];
   assign entry_sum  = load_base + req_entry;
   // no set bits above the one under the scan
   assign map_last   = (map_ff[BitmapBits-1:1] == '0);
   assign slot_free  = ~rsp_valid_ff | rsp_ready;
   assign load_out   = (cmd.accept & entry_even) | (cmd.scan_step & map_ff[0]);

   assign status.slot_free    = slot_free;
   assign status.entry_even   = entry_even;
   assign status.cursor_valid = cursor_valid_ff;
   assign status.map_bit      = map_ff[0];
   assign status.map_last     = map_last;

   // Next-state logic
   always_comb begin
      cursor_in       = cursor_ff;
      cursor_valid_in = cursor_valid_ff;
      map_in          = map_ff;
      scan_addr_in    = scan_addr_ff;
      rsp_addr_in     = rsp_addr_ff;
      rsp_last_in     = rsp_last_ff;

      if (cmd.accept) begin
         cursor_valid_in = (entry_even | cursor_valid_ff) & ~req_table_end;
         map_in          = req_entry[BitmapBits:1];
         scan_addr_in    = cursor_ff;
         if (entry_even) begin
            cursor_in   = entry_sum;
            rsp_addr_in = entry_sum;
            rsp_last_in = 1'b1;
         end
      end

      if (cmd.scan_step) begin
         map_in       = {1'b0, map_ff[BitmapBits-1:1]};
         scan_addr_in = scan_addr_ff + WordStep;
         if (map_ff[0]) begin
            rsp_addr_in = scan_addr_ff;
            rsp_last_in = map_last;
         end
      end

      if (cmd.advance_word) begin
         cursor_in = cursor_ff + WordStep;
      end
      if (cmd.advance_run) begin
         cursor_in = cursor_ff + RunStep;
      end

      // output register empties on handshake, refills on load
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff       <= '0;
         cursor_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cursor_ff       <= cursor_in;
         cursor_valid_ff <= cursor_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      map_ff       <= map_in;
      scan_addr_ff <= scan_addr_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_patch_address = rsp_addr_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   // An address entry shows its single address as the last of its run
   a_addr_entry_out: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && entry_even) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("address entry did not load the output register");

   // A set bitmap bit always produces a result
   a_bit_emits: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && map_ff[0]) |=> rsp_valid_ff)
      else $error("set bitmap bit produced no result");

   // A bitmap with no cursor leaves the cursor alone
   a_orphan_bitmap: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && !entry_even && !cursor_valid_ff) |=> $stable(cursor_ff))
      else $error("cursor moved on a bitmap entry without a cursor");

endmodule

`default_nettype wire

### src/relr_ctrl.sv
// Controller of the RELR decoder: accepts entries, sequences the bitmap scan and cursor update.
// Depends on relr_pkg; commands relr_datapath.
`timescale 1ns / 1ps
`default_nettype none

module relr_ctrl import relr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.slot_free;
            if (req_valid && status.slot_free) begin
               cmd.accept = 1'b1;
               if (status.entry_even) begin
                  state_in = ST_ADV_WORD;
               end else if (status.cursor_valid) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // hold on a set bit while the output register is full
            if (!status.map_bit || status.slot_free) begin
               cmd.scan_step = 1'b1;
               if (status.map_last) begin
                  state_in = ST_ADV_RUN;
               end
            end
         end
         ST_ADV_WORD: begin
            cmd.advance_word = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_ADV_RUN: begin
            cmd.advance_run = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_run_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV_RUN) |-> ($past(state_ff) == ST_SCAN))
      else $error("bitmap advance without a scan");

   a_word_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV_WORD) |-> $past(cmd.accept && status.entry_even))
      else $error("word advance without an address entry");

   // Entries are only taken between runs
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE))
      else $error("entry port ready outside idle");

endmodule

`default_nettype wire

### src/relr_relocation_decoder.sv
// RELR relocation decoder: takes 64-bit packed entries and returns the addresses of words
// to patch. An address entry is accepted and then updates the cursor. A bitmap entry is
// accepted, then scanned one bit per cycle by a shift register up to its highest set bit
// (at least one bit, at most 63), holding on a set bit while the result side stalls, and
// then updates the cursor. A bitmap entry that arrives with no cursor is only accepted.
// load_base sits at byte address 0 of the register port and must only be written while
// the block is idle.
// Depends on relr_pkg, relr_if, relr_ctrl and relr_datapath.
`timescale 1ns / 1ps
`default_nettype none

module relr_relocation_decoder import relr_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   relr_req_if.sink                     req_chan,
   relr_rsp_if.source                   rsp_chan,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0]      csr_prdata,
   output logic                         csr_pready
);

   logic [AddrWidth-1:0] load_base_ff;
   logic                 csr_write;
   logic                 csr_hit;
   cmd_type              cmd;
   status_type           status;
   logic                 req_ready;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CsrIndexBit] == RegLoadBase);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_hit;
   assign csr_prdata = csr_hit ? load_base_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_base_ff <= '0;
      end else if (csr_write) begin
         load_base_ff <= csr_pwdata;
      end
   end

   relr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   relr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .load_base         (load_base_ff),
      .req_entry         (req_chan.entry),
      .req_table_end     (req_chan.table_end),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_patch_address (rsp_chan.patch_address),
      .rsp_last_of_run   (rsp_chan.last_of_run)
   );

   assign req_chan.ready = req_ready;

endmodule

`default_nettype wire
